[hdl/lrs_pkg.sv]
package lrs_pkg;

    // One distance cell; values stay at or below nine inside the update.
    localparam int DIST_W = 4;
    typedef logic [DIST_W-1:0] dist_t;

    // Field and register widths.
    localparam int SYMBOL_W = 8;
    localparam int TARGET_W = 64;
    localparam int LENGTH_W = 4;
    localparam int LIMIT_W  = 3;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    localparam cfg_index_t REG_TARGET_CHARS = 2'd0;
    localparam cfg_index_t REG_WORD_LENGTH  = 2'd1;
    localparam cfg_index_t REG_EDIT_LIMIT   = 2'd2;

    // Reset value of the edit limit register and the saturation level that follows.
    localparam logic [LIMIT_W-1:0] EDIT_LIMIT_RESET = 3'd1;
    localparam dist_t RESET_SAT = DIST_W'(EDIT_LIMIT_RESET) + 4'd1;

    // Operands of one cell update.
    typedef struct packed {
        dist_t up_old;    // this cell before the symbol
        dist_t diag_old;  // previous cell before the symbol
        dist_t left_new;  // previous cell after the symbol
        dist_t sat;       // saturation level, edit limit plus one
        logic  mismatch;  // symbol differs from the target character
        logic  first;     // this is cell zero
        logic  active;    // cell lies within the word length
    } cell_in_t;

endpackage

[hdl/levenshtein_row_step.sv]
// Channel   Direction  Ports
// s_        in         s_valid, s_ready, s_symbol, s_begin_word
// m_        out        m_valid, m_ready, m_is_match, m_can_match
// cfg_      in         cfg_wr_en, cfg_index, cfg_data
//
// Each item is accepted in the idle state, then the row rotates once, cell by
// cell, through the shared cell update unit.
// Reset loads the empty-input row for an edit limit of one and clears the
// handshakes. A new item is accepted while a result waits on m_; the row
// pauses on its last cell only while the result register is still full.
module levenshtein_row_step
    import lrs_pkg::*;
#(
    parameter int MAX_WORD = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SYMBOL_W-1:0]    s_symbol,
    input  logic                   s_begin_word,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_is_match,
    output logic                   m_can_match,

    input  logic                   cfg_wr_en,
    input  cfg_index_t             cfg_index,
    input  logic [TARGET_W-1:0]    cfg_data
);

    localparam int DEPTH = MAX_WORD + 1;
    localparam int CNT_W = $clog2(DEPTH);
    localparam int LEN_W = (CNT_W > LENGTH_W) ? CNT_W : LENGTH_W;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                 state_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [SYMBOL_W-1:0]    sym_reg;
    logic                   begin_reg;
    logic [TARGET_W-1:0]    tgt_reg;
    dist_t                  prev_old_reg;
    dist_t                  prev_new_reg;
    dist_t                  best_reg;
    dist_t                  last_reg;
    logic                   m_valid_reg;
    logic                   m_is_match_reg;
    logic                   m_can_match_reg;

    logic [TARGET_W-1:0]    target_chars_reg;
    logic [LENGTH_W-1:0]    word_length_reg;
    logic [LIMIT_W-1:0]     edit_limit_reg;

    dist_t                  sat;
    dist_t                  head;
    dist_t                  old_val;
    dist_t                  rst_val;
    dist_t                  new_val;
    dist_t                  best_next;
    dist_t                  last_next;
    logic [LEN_W-1:0]       cnt_ext;
    logic [LEN_W-1:0]       n_len;
    logic                   active;
    logic                   at_last_cell;
    logic                   final_cell;
    logic                   out_free;
    logic                   shift_en;
    cell_in_t               cell_in;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_chars_reg <= '0;
            word_length_reg  <= '0;
            edit_limit_reg   <= EDIT_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_TARGET_CHARS: target_chars_reg <= cfg_data;
                REG_WORD_LENGTH:  word_length_reg  <= cfg_data[LENGTH_W-1:0];
                REG_EDIT_LIMIT:   edit_limit_reg   <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Cell position, used length and the value of this cell in the empty-input row.
    always_comb begin
        sat     = DIST_W'(edit_limit_reg) + 4'd1;
        cnt_ext = LEN_W'(cnt_reg);
        n_len   = (LEN_W'(word_length_reg) > LEN_W'(MAX_WORD)) ?
                  LEN_W'(MAX_WORD) : LEN_W'(word_length_reg);
        active       = (cnt_ext <= n_len);
        at_last_cell = (cnt_ext == n_len);
        final_cell   = (cnt_reg == CNT_W'(MAX_WORD));
        rst_val = (cnt_ext < LEN_W'(sat)) ? DIST_W'(cnt_ext) : sat;
        old_val = begin_reg ? rst_val : head;
    end

    // Operands for the shared cell update unit.
    always_comb begin
        cell_in.up_old   = old_val;
        cell_in.diag_old = prev_old_reg;
        cell_in.left_new = prev_new_reg;
        cell_in.sat      = sat;
        cell_in.mismatch = (sym_reg != tgt_reg[SYMBOL_W-1:0]);
        cell_in.first    = (cnt_reg == '0);
        cell_in.active   = active;
    end

    lrs_cell u_cell (
        .cell_in  (cell_in),
        .cell_out (new_val)
    );

    // The row advances one cell a cycle; the last cell waits for a free result slot.
    assign out_free = !m_valid_reg || m_ready;
    assign shift_en = (state_reg == ST_RUN) && (!final_cell || out_free);

    lrs_row_store #(
        .DEPTH (DEPTH)
    ) u_row (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (shift_en),
        .tail_in  (new_val),
        .head_out (head)
    );

    // Running minimum over the used cells and the value of the last used cell.
    always_comb begin
        best_next = best_reg;
        if (cnt_reg == '0) begin
            best_next = new_val;
        end else if (active && (new_val < best_reg)) begin
            best_next = new_val;
        end
        last_next = at_last_cell ? new_val : last_reg;
    end

    // Sequencer, datapath registers and the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // A result taken now frees the slot unless the next one lands this cycle.
            if (m_valid_reg && m_ready && !(shift_en && final_cell)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_RUN;
                        cnt_reg   <= '0;
                        sym_reg   <= s_symbol;
                        begin_reg <= s_begin_word;
                        tgt_reg   <= target_chars_reg;
                    end
                end
                ST_RUN: begin
                    if (shift_en) begin
                        prev_old_reg <= old_val;
                        prev_new_reg <= new_val;
                        best_reg     <= best_next;
                        last_reg     <= last_next;
                        // Target characters leave one byte per cell after cell zero.
                        if (cnt_reg != '0) begin
                            tgt_reg <= {{SYMBOL_W{1'b0}}, tgt_reg[TARGET_W-1:SYMBOL_W]};
                        end
                        if (final_cell) begin
                            state_reg       <= ST_IDLE;
                            m_valid_reg     <= 1'b1;
                            m_is_match_reg  <= (last_next <= DIST_W'(edit_limit_reg));
                            m_can_match_reg <= (best_next <= DIST_W'(edit_limit_reg));
                        end else begin
                            cnt_reg <= cnt_reg + CNT_W'(1);
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_is_match  = m_is_match_reg;
    assign m_can_match = m_can_match_reg;

endmodule

[hdl/lrs_cell.sv]
module lrs_cell
    import lrs_pkg::*;
(
    input  cell_in_t cell_in,
    output dist_t    cell_out
);

    logic [DIST_W:0] up_inc;
    logic [DIST_W:0] left_inc;
    logic [DIST_W:0] diag_sum;
    logic [DIST_W:0] best;
    logic [DIST_W:0] sat_ext;

    // Insert, delete and substitute costs, then saturate.
    always_comb begin
        up_inc   = {1'b0, cell_in.up_old} + 5'd1;
        left_inc = {1'b0, cell_in.left_new} + 5'd1;
        diag_sum = {1'b0, cell_in.diag_old} + {4'd0, cell_in.mismatch};
        sat_ext  = {1'b0, cell_in.sat};

        if (cell_in.first) begin
            best = up_inc;
        end else begin
            best = (left_inc < up_inc) ? left_inc : up_inc;
            best = (diag_sum < best) ? diag_sum : best;
        end
        best = (sat_ext < best) ? sat_ext : best;

        // Cells past the word length keep their value.
        if (cell_in.active) begin
            cell_out = best[DIST_W-1:0];
        end else begin
            cell_out = cell_in.up_old;
        end
    end

endmodule

[hdl/lrs_row_store.sv]
module lrs_row_store
    import lrs_pkg::*;
#(
    parameter int DEPTH = 9
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  shift_en,
    input  dist_t tail_in,
    output dist_t head_out
);

    dist_t cells_reg [DEPTH];

    assign head_out = cells_reg[0];

    // Rotating shift line: the head cell leaves and its update enters at the tail.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DEPTH; k++) begin
                cells_reg[k] <= (DIST_W'(k) < RESET_SAT && k < 16) ? DIST_W'(k) : RESET_SAT;
            end
        end else if (shift_en) begin
            for (int k = 0; k < DEPTH - 1; k++) begin
                cells_reg[k] <= cells_reg[k+1];
            end
            cells_reg[DEPTH-1] <= tail_in;
        end
    end

endmodule
